### src/psra_pkg.sv
package psra_pkg;

  // Table and window geometry
  localparam int MAX_SENSORS = 16;
  localparam int WINDOW      = 5;

  localparam int TEMP_W = 16;
  localparam int ID_W   = 16;

  // Fill count holds 0..WINDOW
  localparam int FILL_W = $clog2(WINDOW + 1);
  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(WINDOW);
  localparam logic [FILL_W-1:0] FILL_LAST = FILL_W'(WINDOW - 1);

  // Window sum, offset divider
  localparam int SUM_W     = TEMP_W + $clog2(WINDOW);
  // Adding WINDOW*2^15 makes the dividend non-negative; the quotient then
  // carries a bias of 2^15, removed by flipping its top bit.
  localparam logic [SUM_W-1:0] AVG_OFFSET = SUM_W'(WINDOW * 32768);

  // Divide by WINDOW as a multiply by ceil(2^DIV_SHIFT / WINDOW) and a shift;
  // exact for every dividend below 2^SUM_W.
  localparam int DIV_SHIFT = SUM_W + $clog2(WINDOW);
  localparam int DIV_MUL_W = SUM_W + 1;
  localparam int PROD_W    = SUM_W + DIV_MUL_W;
  localparam logic [DIV_MUL_W-1:0] DIV_MUL =
    DIV_MUL_W'(((1 << DIV_SHIFT) + WINDOW - 1) / WINDOW);

  // Threshold reset values, Q8.8 (25.0 and 10.0)
  localparam logic signed [TEMP_W-1:0] MAX_TEMP_RESET = 16'sd6400;
  localparam logic signed [TEMP_W-1:0] MIN_TEMP_RESET = 16'sd2560;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_TEMP = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_TEMP = 1'b1;

  // Item opcodes
  localparam logic OP_MAP     = 1'b0;
  localparam logic OP_READING = 1'b1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_UNKNOWN = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    CELL_NOP,
    CELL_CLAIM,
    CELL_ROOM,
    CELL_PUSH,
    CELL_ROTATE,
    CELL_AVG
  } cell_op_t;

  // Broadcast command; a cell acts on it only when selected
  typedef struct packed {
    cell_op_t                  op;
    logic [ID_W-1:0]           sensor;
    logic [ID_W-1:0]           room_id;
    logic signed [TEMP_W-1:0]  data;
  } cell_cmd_t;

  // Carries passed from cell to cell down the row
  typedef struct packed {
    logic hit;
    logic free;
  } chain_t;

  typedef struct packed {
    logic                      first_hit;
    logic                      first_free;
    logic [ID_W-1:0]           room;
    logic signed [TEMP_W-1:0]  avg;
    logic [FILL_W-1:0]         fill;
    logic signed [TEMP_W-1:0]  tap;
  } cell_view_t;

endpackage

### src/psra_cell.sv
module psra_cell (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   sel,
  input  psra_pkg::cell_cmd_t    cmd,
  input  psra_pkg::chain_t       chain_in,
  output psra_pkg::chain_t       chain_out,
  output psra_pkg::cell_view_t   view
);

  logic                                   valid_r, valid_nxt;
  logic [psra_pkg::ID_W-1:0]              sensor_r, sensor_nxt;
  logic [psra_pkg::ID_W-1:0]              room_r, room_nxt;
  logic signed [psra_pkg::TEMP_W-1:0]     avg_r, avg_nxt;
  logic [psra_pkg::FILL_W-1:0]            fill_r, fill_nxt;
  logic signed [psra_pkg::TEMP_W-1:0]     ring_r   [psra_pkg::WINDOW];
  logic signed [psra_pkg::TEMP_W-1:0]     ring_nxt [psra_pkg::WINDOW];
  logic                                   my_hit;
  logic                                   do_shift;
  logic signed [psra_pkg::TEMP_W-1:0]     shift_in;

  assign my_hit = valid_r && (sensor_r == cmd.sensor);

  assign chain_out.hit  = chain_in.hit | my_hit;
  assign chain_out.free = chain_in.free | !valid_r;

  assign view.first_hit  = my_hit & !chain_in.hit;
  assign view.first_free = !valid_r & !chain_in.free;
  assign view.room       = room_r;
  assign view.avg        = avg_r;
  assign view.fill       = fill_r;
  assign view.tap        = ring_r[psra_pkg::WINDOW-1];

  // Ring is a shift line: push drops the oldest, rotate recirculates it
  assign do_shift = sel && (cmd.op == psra_pkg::CELL_PUSH || cmd.op == psra_pkg::CELL_ROTATE);
  assign shift_in = (cmd.op == psra_pkg::CELL_PUSH) ? cmd.data : ring_r[psra_pkg::WINDOW-1];

  always_comb begin
    ring_nxt[0] = do_shift ? shift_in : ring_r[0];
    for (int j = 1; j < psra_pkg::WINDOW; j++) begin
      ring_nxt[j] = do_shift ? ring_r[j-1] : ring_r[j];
    end
  end

  always_comb begin
    valid_nxt  = valid_r;
    sensor_nxt = sensor_r;
    room_nxt   = room_r;
    avg_nxt    = avg_r;
    fill_nxt   = fill_r;
    if (sel) begin
      case (cmd.op)
        psra_pkg::CELL_CLAIM: begin
          valid_nxt  = 1'b1;
          sensor_nxt = cmd.sensor;
          room_nxt   = cmd.room_id;
          avg_nxt    = '0;
          fill_nxt   = '0;
        end
        psra_pkg::CELL_ROOM: begin
          room_nxt = cmd.room_id;
        end
        psra_pkg::CELL_PUSH: begin
          if (fill_r != psra_pkg::FILL_FULL) begin
            fill_nxt = fill_r + psra_pkg::FILL_W'(1);
          end
        end
        psra_pkg::CELL_AVG: begin
          avg_nxt = cmd.data;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sensor_r <= sensor_nxt;
    room_r   <= room_nxt;
    avg_r    <= avg_nxt;
    fill_r   <= fill_nxt;
    for (int j = 0; j < psra_pkg::WINDOW; j++) begin
      ring_r[j] <= ring_nxt[j];
    end
  end

endmodule

### src/psra_div.sv
module psra_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [psra_pkg::SUM_W-1:0]    num,
  output logic                          done,
  output logic [psra_pkg::TEMP_W-1:0]   quot
);

  logic                              run_r;
  logic                              done_r;
  logic [psra_pkg::SUM_W-1:0]        num_r;
  logic [psra_pkg::TEMP_W-1:0]       quot_r;
  logic [psra_pkg::PROD_W-1:0]       prod;

  // Latch the dividend, then multiply by the reciprocal and keep the top bits
  assign prod = psra_pkg::PROD_W'(num_r) * psra_pkg::PROD_W'(psra_pkg::DIV_MUL);

  assign done = done_r;
  assign quot = quot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= start;
      done_r <= run_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
    end
    if (run_r) begin
      quot_r <= prod[psra_pkg::DIV_SHIFT +: psra_pkg::TEMP_W];
    end
  end

endmodule

### src/per_sensor_running_average_alarm.sv
// Per-sensor running-average temperature monitor.
// Input channel: an item is taken at a clock edge with start high and busy
// low. in_opcode selects a map word (bind in_sensor to in_room_id) or a
// reading word (in_reading, Q8.8). Every item yields exactly one result word,
// shown for one cycle with out_valid high; the receiver cannot stall it.
// Configuration: cfg_valid/cfg_ready write channel, cfg_ready is always high;
// index 0 is the upper threshold, index 1 the lower one. Write only while idle.
// Structure: a row of MAX_SENSORS cells, one table entry each, holding the
// entry and its ring of the last WINDOW readings. Lookup and free-slot search
// ripple hit/free carries cell to cell; the ring is read out by rotating it.
// Sequence: map words, unknown sensors and readings into a ring not yet full
// pass the search, apply and result states; a new item is taken only once
// the result of the last one is shown. A reading that fills or refreshes the
// ring also rotates the whole ring through the accumulator, then divides the
// window sum by a reciprocal multiplication before its result is shown.
// Reset (synchronous, rst_n low) empties the table and loads thresholds of
// 25.0 and 10.0 degrees; ring contents are not cleared and are never read
// before the entry has written all WINDOW slots.
module per_sensor_running_average_alarm (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 in_opcode,
  input  logic [psra_pkg::ID_W-1:0]            in_sensor,
  input  logic [psra_pkg::ID_W-1:0]            in_room_id,
  input  logic signed [psra_pkg::TEMP_W-1:0]   in_reading,
  output logic                                 out_valid,
  output logic [1:0]                           out_status,
  output logic [psra_pkg::ID_W-1:0]            out_room_out,
  output logic signed [psra_pkg::TEMP_W-1:0]   out_average,
  output logic                                 out_average_valid,
  output logic                                 out_too_hot,
  output logic                                 out_too_cold,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [psra_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [psra_pkg::TEMP_W-1:0]          cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_APPLY,
    S_SUM,
    S_DIV,
    S_RESULT
  } state_t;

  state_t state_r, state_nxt;

  // Thresholds
  logic signed [psra_pkg::TEMP_W-1:0] max_r, min_r;

  // Held item
  logic                                op_r, op_nxt;
  logic [psra_pkg::ID_W-1:0]           id_r, id_nxt;
  logic [psra_pkg::ID_W-1:0]           room_r, room_nxt;
  logic signed [psra_pkg::TEMP_W-1:0]  value_r, value_nxt;
  psra_pkg::status_t                   status_r, status_nxt;
  logic                                claim_r, claim_nxt;
  logic [psra_pkg::MAX_SENSORS-1:0]    sel_r, sel_nxt;

  // Window sum
  logic signed [psra_pkg::SUM_W-1:0]   acc_r, acc_nxt;
  logic [psra_pkg::FILL_W-1:0]         cnt_r, cnt_nxt;

  // Result word
  logic                                out_valid_r, out_valid_nxt;
  psra_pkg::status_t                   out_status_r, out_status_nxt;
  logic [psra_pkg::ID_W-1:0]           out_room_r, out_room_nxt;
  logic signed [psra_pkg::TEMP_W-1:0]  out_avg_r, out_avg_nxt;
  logic                                out_av_r, out_av_nxt;
  logic                                out_hot_r, out_hot_nxt;
  logic                                out_cold_r, out_cold_nxt;

  // Cell row
  psra_pkg::cell_cmd_t                 cell_cmd;
  psra_pkg::chain_t                    chain [psra_pkg::MAX_SENSORS+1];
  psra_pkg::cell_view_t                views [psra_pkg::MAX_SENSORS];
  psra_pkg::cell_view_t                sel_view;
  logic [psra_pkg::MAX_SENSORS-1:0]    hit_vec, free_vec;
  logic                                found, any_free, sel_valid_avg;

  // Divider
  logic                                div_start;
  logic [psra_pkg::SUM_W-1:0]          div_num;
  logic                                div_done;
  logic [psra_pkg::TEMP_W-1:0]         div_quot;

  assign chain[0] = '0;

  for (genvar g = 0; g < psra_pkg::MAX_SENSORS; g++) begin : g_cell
    psra_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .sel       (sel_r[g]),
      .cmd       (cell_cmd),
      .chain_in  (chain[g]),
      .chain_out (chain[g+1]),
      .view      (views[g])
    );
  end

  psra_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign found    = chain[psra_pkg::MAX_SENSORS].hit;
  assign any_free = chain[psra_pkg::MAX_SENSORS].free;

  // First hit and first free slot, and the view of the selected entry
  always_comb begin
    sel_view = '0;
    for (int i = 0; i < psra_pkg::MAX_SENSORS; i++) begin
      hit_vec[i]  = views[i].first_hit;
      free_vec[i] = views[i].first_free;
      if (sel_r[i]) begin
        sel_view = views[i];
      end
    end
  end

  assign sel_valid_avg = (sel_view.fill == psra_pkg::FILL_FULL);

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    id_nxt         = id_r;
    room_nxt       = room_r;
    value_nxt      = value_r;
    status_nxt     = status_r;
    claim_nxt      = claim_r;
    sel_nxt        = sel_r;
    acc_nxt        = acc_r;
    cnt_nxt        = cnt_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_room_nxt   = out_room_r;
    out_avg_nxt    = out_avg_r;
    out_av_nxt     = out_av_r;
    out_hot_nxt    = out_hot_r;
    out_cold_nxt   = out_cold_r;
    div_start      = 1'b0;
    div_num        = $unsigned(acc_nxt) + psra_pkg::AVG_OFFSET;

    cell_cmd.op        = psra_pkg::CELL_NOP;
    cell_cmd.sensor    = id_r;
    cell_cmd.room_id   = room_r;
    cell_cmd.data      = value_r;

    case (state_r)
      S_IDLE: begin
        // Take the word; cells compare against the held id next cycle
        if (start) begin
          op_nxt    = in_opcode;
          id_nxt    = in_sensor;
          room_nxt  = in_room_id;
          value_nxt = in_reading;
          state_nxt = S_SEARCH;
        end
      end

      S_SEARCH: begin
        claim_nxt = (op_r == psra_pkg::OP_MAP) && !found && any_free;
        if (found) begin
          sel_nxt    = hit_vec;
          status_nxt = psra_pkg::ST_OK;
        end else if (op_r == psra_pkg::OP_MAP && any_free) begin
          sel_nxt    = free_vec;
          status_nxt = psra_pkg::ST_OK;
        end else begin
          sel_nxt    = '0;
          if (op_r == psra_pkg::OP_MAP) begin
            status_nxt = psra_pkg::ST_FULL;
          end else begin
            status_nxt = psra_pkg::ST_UNKNOWN;
          end
        end
        state_nxt = S_APPLY;
      end

      S_APPLY: begin
        state_nxt = S_RESULT;
        if (status_r == psra_pkg::ST_OK) begin
          if (op_r == psra_pkg::OP_MAP) begin
            if (claim_r) begin
              cell_cmd.op = psra_pkg::CELL_CLAIM;
            end else begin
              cell_cmd.op = psra_pkg::CELL_ROOM;
            end
          end else begin
            cell_cmd.op = psra_pkg::CELL_PUSH;
            // This push fills or refreshes the ring: average it
            if (sel_view.fill >= psra_pkg::FILL_LAST) begin
              acc_nxt   = '0;
              cnt_nxt   = '0;
              state_nxt = S_SUM;
            end
          end
        end
      end

      S_SUM: begin
        // Rotate the ring once per cycle, adding the outgoing slot
        cell_cmd.op = psra_pkg::CELL_ROTATE;
        acc_nxt     = acc_r + psra_pkg::SUM_W'($signed(sel_view.tap));
        cnt_nxt     = cnt_r + psra_pkg::FILL_W'(1);
        div_num     = $unsigned(acc_nxt) + psra_pkg::AVG_OFFSET;
        if (cnt_r == psra_pkg::FILL_LAST) begin
          div_start = 1'b1;
          state_nxt = S_DIV;
        end
      end

      S_DIV: begin
        // Hold until the divider's done strobe returns the quotient
        if (div_done) begin
          // Drop the 2^15 bias the offset added
          cell_cmd.op   = psra_pkg::CELL_AVG;
          cell_cmd.data = {~div_quot[psra_pkg::TEMP_W-1], div_quot[psra_pkg::TEMP_W-2:0]};
          state_nxt     = S_RESULT;
        end
      end

      S_RESULT: begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = status_r;
        if (status_r == psra_pkg::ST_OK) begin
          out_room_nxt = sel_view.room;
          out_avg_nxt  = sel_view.avg;
          out_av_nxt   = sel_valid_avg;
          out_hot_nxt  = sel_valid_avg && ($signed(sel_view.avg) > max_r);
          out_cold_nxt = sel_valid_avg && ($signed(sel_view.avg) < min_r);
        end else begin
          out_room_nxt = '0;
          out_avg_nxt  = '0;
          out_av_nxt   = 1'b0;
          out_hot_nxt  = 1'b0;
          out_cold_nxt = 1'b0;
        end
        state_nxt = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State, thresholds and result word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      out_status_r <= psra_pkg::ST_OK;
      out_room_r   <= '0;
      out_avg_r    <= '0;
      out_av_r     <= 1'b0;
      out_hot_r    <= 1'b0;
      out_cold_r   <= 1'b0;
      max_r        <= psra_pkg::MAX_TEMP_RESET;
      min_r        <= psra_pkg::MIN_TEMP_RESET;
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      out_status_r <= out_status_nxt;
      out_room_r   <= out_room_nxt;
      out_avg_r    <= out_avg_nxt;
      out_av_r     <= out_av_nxt;
      out_hot_r    <= out_hot_nxt;
      out_cold_r   <= out_cold_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          psra_pkg::CFG_MAX_TEMP: max_r <= $signed(cfg_data);
          psra_pkg::CFG_MIN_TEMP: min_r <= $signed(cfg_data);
          default: begin
          end
        endcase
      end
    end
  end

  // Held item and sum datapath
  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    id_r     <= id_nxt;
    room_r   <= room_nxt;
    value_r  <= value_nxt;
    status_r <= status_nxt;
    claim_r  <= claim_nxt;
    sel_r    <= sel_nxt;
    acc_r    <= acc_nxt;
    cnt_r    <= cnt_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_room_out      = out_room_r;
  assign out_average       = out_avg_r;
  assign out_average_valid = out_av_r;
  assign out_too_hot       = out_hot_r;
  assign out_too_cold      = out_cold_r;

endmodule

### src/psra_chk.sv
module psra_chk (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 start,
  input logic                                 busy,
  input logic                                 out_valid,
  input logic [1:0]                           out_status,
  input logic [psra_pkg::ID_W-1:0]            out_room_out,
  input logic signed [psra_pkg::TEMP_W-1:0]   out_average,
  input logic                                 out_average_valid,
  input logic                                 out_too_hot,
  input logic                                 out_too_cold
);

  // An accepted word keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("block not busy after accepting a word");

  // One result per word, never in back-to-back cycles
  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for two cycles");

  // Result appears only once the block is idle again
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while busy");

  // Failed lookups carry an all-zero result
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != psra_pkg::ST_OK) |->
      (out_room_out == '0 && out_average == '0 && !out_average_valid &&
       !out_too_hot && !out_too_cold))
    else $error("nonzero fields on a failed lookup");

  // Alarms only with a valid average on a found entry
  a_alarm_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_too_hot || out_too_cold)) |->
      (out_average_valid && out_status == psra_pkg::ST_OK))
    else $error("alarm without a valid average");

endmodule

bind per_sensor_running_average_alarm psra_chk u_psra_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .out_valid         (out_valid),
  .out_status        (out_status),
  .out_room_out      (out_room_out),
  .out_average       (out_average),
  .out_average_valid (out_average_valid),
  .out_too_hot       (out_too_hot),
  .out_too_cold      (out_too_cold)
);
